// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define CHK_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon test block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package pip_pkg;

  // Coordinate width and the widths of the exact arithmetic built on it.
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;

  // Configuration port.
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;
  localparam int IDX_BITS  = ADDR_BITS - 2;

  // Register indexes.
  localparam logic [IDX_BITS-1:0] CFG_STRICT_MODE = IDX_BITS'(0);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } result_t;

endpackage

`default_nettype wire

// ----- design/point_in_polygon_test.sv -----
// Streaming crossing-number point-in-polygon test, top level.
// Depends on pip_pkg for the beat types and arithmetic widths.
//
// Usage: polygon vertices arrive on the vertex channel, one per beat, in
// order around the polygon. The beat that carries a polygon's first vertex
// also carries the query point, which is held for the rest of that polygon;
// the query fields of later beats are ignored. The beat with last_vertex set
// closes the polygon, and exactly one beat then leaves on the result channel.
// Both channels use a valid/ready handshake, and one vertex beat can be taken
// every clock cycle unless the input is held back, across polygon boundaries
// too. The edge that takes a polygon's last vertex loads the coordinate
// differences, a later edge the 34-bit exact products, and a later one the
// result register from the sums, sign tests and parity fold. When the receiver
// stalls, the result register holds its beat while the two arithmetic stages
// keep filling; only once a closing vertex reaches the end of the pipe behind
// a waiting result does the input stop taking beats. strict_mode (address 0,
// reset value 1: a boundary point counts as outside) is written through the
// APB-style port, by the user only while no polygon is in flight; the block
// does not enforce it. A synchronous reset empties the pipe, drops any partial
// polygon, and restores strict_mode to 1; the input is ready on the next cycle.
`default_nettype none

module point_in_polygon_test (
  input  wire                                 clk,
  input  wire                                 rst,
  // Vertex channel.
  input  wire                                 vertex_valid,
  output logic                                vertex_ready,
  input  pip_pkg::vertex_t                    vertex,
  // Result channel.
  output logic                                result_valid,
  input  wire                                 result_ready,
  output pip_pkg::result_t                    result,
  // Configuration port.
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [pip_pkg::ADDR_BITS-1:0]       paddr,
  input  wire  [pip_pkg::DATA_BITS-1:0]       pwdata,
  output logic [pip_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  // ---------------------------------------------------------------------
  // Configuration register. Only bits [ADDR_BITS-1:2] pick the register.
  // ---------------------------------------------------------------------
  logic                          strict_mode;
  logic [pip_pkg::IDX_BITS-1:0]  cfg_idx;

  assign cfg_idx = paddr[pip_pkg::ADDR_BITS-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && cfg_idx == pip_pkg::CFG_STRICT_MODE) begin
      strict_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == pip_pkg::CFG_STRICT_MODE) begin
      prdata[0] = strict_mode;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. The result register only blocks when the beat
  // in the product stage closes a polygon and the previous result waits.
  // ---------------------------------------------------------------------
  logic a_valid, b_valid;
  logic b_last;
  logic a_move, b_move, b_free;
  logic accept;

  assign b_move       = b_valid && !(b_last && result_valid && !result_ready);
  assign b_free       = !b_valid || b_move;
  assign a_move       = a_valid && b_free;
  assign vertex_ready = !a_valid || a_move;
  assign accept       = vertex_valid && vertex_ready;

  // ---------------------------------------------------------------------
  // Polygon context, updated as each vertex is taken: the previous vertex,
  // the first vertex and the held query point.
  // ---------------------------------------------------------------------
  logic                                 in_polygon;
  logic signed [pip_pkg::COORD_BITS-1:0] prev_x, prev_y, first_x, first_y;
  logic signed [pip_pkg::COORD_BITS-1:0] held_query_x, held_query_y;
  logic signed [pip_pkg::COORD_BITS-1:0] qx_cur, qy_cur, fx_cur, fy_cur;

  // On a polygon's first vertex the context comes straight from the beat, so
  // a single-vertex polygon closes onto itself.
  assign qx_cur = in_polygon ? held_query_x : vertex.query_x;
  assign qy_cur = in_polygon ? held_query_y : vertex.query_y;
  assign fx_cur = in_polygon ? first_x : vertex.vertex_x;
  assign fy_cur = in_polygon ? first_y : vertex.vertex_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_polygon <= 1'b0;
    end else if (accept) begin
      in_polygon <= !vertex.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= vertex.vertex_x;
      prev_y <= vertex.vertex_y;
      if (!in_polygon) begin
        first_x      <= vertex.vertex_x;
        first_y      <= vertex.vertex_y;
        held_query_x <= vertex.query_x;
        held_query_y <= vertex.query_y;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: vectors from the query point to the previous, current and
  // first vertices. Edge one runs previous to current, edge two (the
  // closing edge) current to first.
  // ---------------------------------------------------------------------
  logic signed [pip_pkg::DIFF_BITS-1:0] dprev_x, dprev_y, dcur_x, dcur_y, dfirst_x, dfirst_y;
  logic                                 a_first, a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dprev_x  <= pip_pkg::DIFF_BITS'(prev_x) - pip_pkg::DIFF_BITS'(qx_cur);
      dprev_y  <= pip_pkg::DIFF_BITS'(prev_y) - pip_pkg::DIFF_BITS'(qy_cur);
      dcur_x   <= pip_pkg::DIFF_BITS'(vertex.vertex_x) - pip_pkg::DIFF_BITS'(qx_cur);
      dcur_y   <= pip_pkg::DIFF_BITS'(vertex.vertex_y) - pip_pkg::DIFF_BITS'(qy_cur);
      dfirst_x <= pip_pkg::DIFF_BITS'(fx_cur) - pip_pkg::DIFF_BITS'(qx_cur);
      dfirst_y <= pip_pkg::DIFF_BITS'(fy_cur) - pip_pkg::DIFF_BITS'(qy_cur);
      a_first  <= !in_polygon;
      a_last   <= vertex.last_vertex;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: the eight exact products, and whether the query point lies at
  // or above each vertex (vertex y minus query y not above zero). The
  // operands are sign-extended differences, so each product is 17 by 17.
  // ---------------------------------------------------------------------
  logic signed [pip_pkg::PROD_BITS-1:0] p1_xx, p1_yy, p1_xy, p1_yx;
  logic signed [pip_pkg::PROD_BITS-1:0] p2_xx, p2_yy, p2_xy, p2_yx;
  logic                                 le_prev, le_cur, le_first;
  logic                                 b_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      p1_xx    <= pip_pkg::PROD_BITS'(dprev_x) * pip_pkg::PROD_BITS'(dcur_x);
      p1_yy    <= pip_pkg::PROD_BITS'(dprev_y) * pip_pkg::PROD_BITS'(dcur_y);
      p1_xy    <= pip_pkg::PROD_BITS'(dprev_x) * pip_pkg::PROD_BITS'(dcur_y);
      p1_yx    <= pip_pkg::PROD_BITS'(dprev_y) * pip_pkg::PROD_BITS'(dcur_x);
      p2_xx    <= pip_pkg::PROD_BITS'(dcur_x) * pip_pkg::PROD_BITS'(dfirst_x);
      p2_yy    <= pip_pkg::PROD_BITS'(dcur_y) * pip_pkg::PROD_BITS'(dfirst_y);
      p2_xy    <= pip_pkg::PROD_BITS'(dcur_x) * pip_pkg::PROD_BITS'(dfirst_y);
      p2_yx    <= pip_pkg::PROD_BITS'(dcur_y) * pip_pkg::PROD_BITS'(dfirst_x);
      le_prev  <= dprev_y[pip_pkg::DIFF_BITS-1] || (dprev_y == '0);
      le_cur   <= dcur_y[pip_pkg::DIFF_BITS-1] || (dcur_y == '0);
      le_first <= dfirst_y[pip_pkg::DIFF_BITS-1] || (dfirst_y == '0);
      b_first  <= a_first;
      b_last   <= a_last;
    end
  end

  // ---------------------------------------------------------------------
  // Edge evaluation. The point is on an edge when the dot product is not
  // above zero and the cross product is zero. Otherwise the parity flips
  // when the edge straddles the point's height and the cross product has
  // the matching sign. Once a boundary hit is seen the parity no longer
  // matters, so both edges can be folded in together.
  // ---------------------------------------------------------------------
  logic signed [pip_pkg::SUM_BITS-1:0] dot1, crs1, dot2, crs2;
  logic on1, on2, tog1, tog2;
  logic crs1_pos, crs1_neg, crs2_pos, crs2_neg;
  logic parity, hit_edge;
  logic parity_next, hit_edge_next;

  assign dot1 = pip_pkg::SUM_BITS'(p1_xx) + pip_pkg::SUM_BITS'(p1_yy);
  assign crs1 = pip_pkg::SUM_BITS'(p1_xy) - pip_pkg::SUM_BITS'(p1_yx);
  assign dot2 = pip_pkg::SUM_BITS'(p2_xx) + pip_pkg::SUM_BITS'(p2_yy);
  assign crs2 = pip_pkg::SUM_BITS'(p2_xy) - pip_pkg::SUM_BITS'(p2_yx);

  assign crs1_neg = crs1[pip_pkg::SUM_BITS-1];
  assign crs1_pos = !crs1_neg && (crs1 != '0);
  assign crs2_neg = crs2[pip_pkg::SUM_BITS-1];
  assign crs2_pos = !crs2_neg && (crs2 != '0);

  assign on1 = (dot1[pip_pkg::SUM_BITS-1] || dot1 == '0) && (crs1 == '0);
  assign on2 = (dot2[pip_pkg::SUM_BITS-1] || dot2 == '0) && (crs2 == '0);

  assign tog1 = !on1 && ((le_prev && !le_cur && crs1_pos) || (!le_prev && le_cur && crs1_neg));
  assign tog2 = !on2 && ((le_cur && !le_first && crs2_pos) || (!le_cur && le_first && crs2_neg));

  always_comb begin
    // A polygon's first vertex has no incoming edge and starts fresh.
    hit_edge_next = !b_first && hit_edge;
    parity_next   = !b_first && parity;
    if (!b_first) begin
      hit_edge_next = hit_edge_next || on1;
      parity_next   = parity_next ^ tog1;
    end
    if (b_last) begin
      hit_edge_next = hit_edge_next || on2;
      parity_next   = parity_next ^ tog2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity   <= 1'b0;
      hit_edge <= 1'b0;
    end else if (b_move) begin
      parity   <= parity_next;
      hit_edge <= hit_edge_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_move && b_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move && b_last) begin
      result.on_boundary <= hit_edge_next;
      result.inside_res  <= hit_edge_next ? !strict_mode : parity_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/pip_checker.sv -----
// Port-level checker for the point-in-polygon test block, with its bind.
// Depends on pip_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pip_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          vertex_ready,
  input wire                          result_valid,
  input wire                          result_ready,
  input pip_pkg::result_t             result,
  input wire                          pready
);

  // A stalled result beat stays put.
  `CHK_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "result beat changed while stalled")

  // Reset empties the pipe and leaves the input open.
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid && vertex_ready, "pipe not empty after reset")

  // With the result register empty nothing can hold the input back.
  `CHK_ASSERT(a_ready_when_empty, clk, rst, !result_valid |-> vertex_ready, "input blocked with empty result register")

  // The configuration port never inserts wait states.
  `CHK_ASSERT(a_pready_high, clk, rst, pready, "pready dropped")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_ready (vertex_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .pready       (pready)
);

`default_nettype wire

// ----- bench/tb_point_in_polygon_test.sv -----
// Self-checking bench for the streaming crossing-number point-in-polygon block.
// Depends on pip_pkg for the vertex and result beat types and port widths.
// Holds a scoreboard class with its own predictor; plain tasks drive the ports.
`timescale 1ns / 100ps

module tb_point_in_polygon_test;

  typedef logic signed [pip_pkg::COORD_BITS-1:0] coord_t;

  // Polygon predictor and result store. Every accepted vertex beat is
  // folded into a private copy of the block's state; a closing vertex
  // yields the verdict that must later leave on the result channel.
  class pip_scoreboard;
    bit      strict_mode = 1'b1;
    coord_t  first_x, first_y, prev_x, prev_y, held_qx, held_qy;
    bit      in_polygon, parity, hit_edge;
    pip_pkg::result_t awaited_results[$];
    int      errors, beats_seen, polygons_closed, boundary_hits, inside_count;

    function new();
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      held_qx = '0; held_qy = '0;
      in_polygon = 1'b0; parity = 1'b0; hit_edge = 1'b0;
      errors = 0; beats_seen = 0; polygons_closed = 0;
      boundary_hits = 0; inside_count = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return awaited_results.size();
    endfunction

    // One edge from a to b against the held query point, in exact integers.
    function void examine_edge(longint ax, longint ay, longint bx, longint by);
      longint px, py, ux, uy, vx, vy, dotv, crs;
      int     d;
      px = held_qx;
      py = held_qy;
      ux = ax - px; uy = ay - py;
      vx = bx - px; vy = by - py;
      dotv = ux * vx + uy * vy;
      crs  = ux * vy - uy * vx;
      if (dotv <= 0 && crs == 0) begin
        hit_edge = 1'b1;
        return;
      end
      d = ((py >= ay) ? 1 : 0) - ((py >= by) ? 1 : 0);
      if ((d > 0 && crs > 0) || (d < 0 && crs < 0)) parity = !parity;
    endfunction

    function void take_vertex(pip_pkg::vertex_t v);
      pip_pkg::result_t r;
      beats_seen++;
      if (!in_polygon) begin
        first_x = v.vertex_x;
        first_y = v.vertex_y;
        held_qx = v.query_x;
        held_qy = v.query_y;
        parity = 1'b0;
        hit_edge = 1'b0;
        in_polygon = 1'b1;
      end else if (!hit_edge) begin
        examine_edge(prev_x, prev_y, v.vertex_x, v.vertex_y);
      end
      prev_x = v.vertex_x;
      prev_y = v.vertex_y;
      if (v.last_vertex) begin
        if (!hit_edge) examine_edge(v.vertex_x, v.vertex_y, first_x, first_y);
        r.on_boundary = hit_edge;
        r.inside_res  = hit_edge ? !strict_mode : parity;
        awaited_results.insert(awaited_results.size(), r);
        in_polygon = 1'b0;
        polygons_closed++;
        if (hit_edge) boundary_hits++;
        if (r.inside_res) inside_count++;
      end
    endfunction

    task check_result(pip_pkg::result_t got);
      pip_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result beat %b with no polygon outstanding", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.inside_res !== want.inside_res)
        report($sformatf("inside_res %b, predicted %b", got.inside_res, want.inside_res));
      if (got.on_boundary !== want.on_boundary)
        report($sformatf("on_boundary %b, predicted %b", got.on_boundary, want.on_boundary));
    endtask
  endclass

  // The drain waits out the two arithmetic stages and the output register and
  // lets a trailing beat settle before the configuration is touched.
  localparam int DRAIN_CYCLES      = 8;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int HOLD_OFF_CYCLES   = 200;
  localparam int BEATS_PER_PHASE   = 110;
  localparam int RANDOM_PHASES     = 5;
  localparam int PRESSURE_PHASE    = 4;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          vertex_valid = 1'b0;
  logic                          vertex_ready;
  pip_pkg::vertex_t              vertex = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  pip_pkg::result_t              result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pip_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [pip_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [pip_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  pip_scoreboard    sb;
  pip_pkg::vertex_t polygon_beats[$];
  int               src_idle_pct = 0;
  int               sink_stall_pct = 0;
  bit               hold_active = 1'b0;
  int               cycle_count = 0;

  point_in_polygon_test uut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL point_in_polygon_test");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before the block's own
  // registers move. The vertex beat is folded in before any result beat is
  // checked, although the pipe latency means the two never meet.
  always @(posedge clk) begin
    if (!rst) begin
      if (vertex_valid && vertex_ready) sb.take_vertex(vertex);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // Receiver. It stalls at random with the current percentage, and during
  // a hold-off it refuses every beat so that the pipe backs up into the
  // vertex channel.
  always @(negedge clk) begin
    if (hold_active) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // One of the awkward coordinate values, or now and then any value.
  function automatic int pick_extreme();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return rnd_range(-32768, 32767);
    endcase
  endfunction

  task automatic push_vertex(int x, int y, int qx, int qy, bit last);
    pip_pkg::vertex_t v;
    v.vertex_x    = coord_t'(x);
    v.vertex_y    = coord_t'(y);
    v.query_x     = coord_t'(qx);
    v.query_y     = coord_t'(qy);
    v.last_vertex = last;
    polygon_beats.insert(polygon_beats.size(), v);
  endtask

  // A random polygon. Most are small shapes on a tight grid, where shared
  // rows, collinear edges and points on vertices are common; the query is
  // often snapped onto a vertex or the midpoint of an edge. The rest spread
  // over the full range or sit on the extremes to stress the exact products.
  // Query fields after the first beat are random, as the block ignores them.
  task automatic queue_random_polygon();
    int xs[8];
    int ys[8];
    int n, kind, bx, by, qx, qy, e, j;
    n    = ($urandom_range(19) == 0) ? 1 : int'($urandom_range(2, 8));
    kind = $urandom_range(99);
    if (kind < 65) begin
      bx = rnd_range(-32759, 32758);
      by = rnd_range(-32759, 32758);
      for (int i = 0; i < n; i++) begin
        xs[i] = bx + rnd_range(-8, 8);
        ys[i] = by + rnd_range(-8, 8);
      end
      qx = bx + rnd_range(-9, 9);
      qy = by + rnd_range(-9, 9);
      if (kind < 25) begin
        e = $urandom_range(n - 1);
        j = (e + 1) % n;
        if ((((xs[e] + xs[j]) & 1) == 0) && (((ys[e] + ys[j]) & 1) == 0)) begin
          qx = (xs[e] + xs[j]) / 2;
          qy = (ys[e] + ys[j]) / 2;
        end else begin
          qx = xs[e];
          qy = ys[e];
        end
      end
    end else if (kind < 85) begin
      for (int i = 0; i < n; i++) begin
        xs[i] = rnd_range(-32768, 32767);
        ys[i] = rnd_range(-32768, 32767);
      end
      qx = rnd_range(-32768, 32767);
      qy = rnd_range(-32768, 32767);
    end else begin
      for (int i = 0; i < n; i++) begin
        xs[i] = pick_extreme();
        ys[i] = pick_extreme();
      end
      qx = pick_extreme();
      qy = pick_extreme();
    end
    for (int i = 0; i < n; i++) begin
      push_vertex(xs[i], ys[i],
                  (i == 0) ? qx : rnd_range(-32768, 32767),
                  (i == 0) ? qy : rnd_range(-32768, 32767),
                  i == n - 1);
    end
  endtask

  // Offers one beat and returns at the falling edge after it is taken.
  // Valid stays high from one beat to the next unless an idle gap is drawn.
  task automatic send_vertex(pip_pkg::vertex_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      vertex_valid <= 1'b0;
      @(negedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queued_beats();
    foreach (polygon_beats[i]) send_vertex(polygon_beats[i]);
    vertex_valid <= 1'b0;
    polygon_beats.delete();
  endtask

  // Waits until every predicted result has been checked, then lets the
  // pipe run dry so that no vertex is still in flight.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes strict_mode through the register port and reads it back.
  task automatic write_strict_mode(bit value);
    logic [pip_pkg::DATA_BITS-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {pip_pkg::CFG_STRICT_MODE, 2'b00};
    pwdata  <= pip_pkg::DATA_BITS'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.strict_mode = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[0] !== value)
      sb.report($sformatf("strict_mode reads back %b after writing %b", readback[0], value));
  endtask

  int src_pct_by_phase[RANDOM_PHASES]  = '{0, 79, 0, 79, 31};
  int sink_pct_by_phase[RANDOM_PHASES] = '{0, 0, 79, 79, 31};

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed polygons, with strict_mode still at its reset value of 1.
    // A square with the point well inside, then the same square with the
    // point on its lower edge.
    push_vertex(0, 0, 5, 5, 1'b0);
    push_vertex(10, 0, -7, 300, 1'b0);
    push_vertex(10, 10, 12345, -1, 1'b0);
    push_vertex(0, 10, -32768, 32767, 1'b1);
    push_vertex(0, 0, 5, 0, 1'b0);
    push_vertex(10, 0, 0, 0, 1'b0);
    push_vertex(10, 10, 0, 0, 1'b0);
    push_vertex(0, 10, 0, 0, 1'b1);
    // A triangle with the point outside it.
    push_vertex(0, 0, 20, 5, 1'b0);
    push_vertex(10, 0, 1, 1, 1'b0);
    push_vertex(0, 10, 1, 1, 1'b1);
    // A single-vertex polygon, once with the point on the vertex and once
    // beside it.
    push_vertex(7, -3, 7, -3, 1'b1);
    push_vertex(7, -3, 8, -3, 1'b1);
    // Repeated vertices give a zero-length edge ahead of a real triangle.
    push_vertex(0, 0, 6, 2, 1'b0);
    push_vertex(0, 0, 0, 0, 1'b0);
    push_vertex(8, 0, 0, 0, 1'b0);
    push_vertex(8, 8, 0, 0, 1'b1);
    // The full coordinate square with the point on one of its corners.
    push_vertex(-32768, -32768, -32768, 32767, 1'b0);
    push_vertex(32767, -32768, 32767, -32768, 1'b0);
    push_vertex(32767, 32767, 0, 0, 1'b0);
    push_vertex(-32768, 32767, -1, -1, 1'b1);
    // An extreme triangle whose long diagonal passes far from the point.
    push_vertex(-32768, -32768, 32767, 0, 1'b0);
    push_vertex(32767, 32767, -32768, -32768, 1'b0);
    push_vertex(-32768, 32767, 32767, 32767, 1'b1);
    send_queued_beats();

    // Random phases. strict_mode flips between them, only once the pipe is
    // empty. The last phase adds a long receiver hold-off while the sender
    // keeps offering beats back to back.
    for (int p = 0; p < RANDOM_PHASES + 1; p++) begin
      wait_drained();
      write_strict_mode(p % 2 == 0 ? 1'b0 : 1'b1);
      if (p == RANDOM_PHASES) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else begin
        src_idle_pct   = src_pct_by_phase[p];
        sink_stall_pct = sink_pct_by_phase[p];
      end
      while (polygon_beats.size() < BEATS_PER_PHASE) queue_random_polygon();
      if (p == PRESSURE_PHASE + 1) begin
        fork
          begin
            @(posedge clk);
            hold_active = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_active = 1'b0;
          end
        join_none
      end
      send_queued_beats();
    end
    wait_drained();

    $display("Checked %0d polygons from %0d vertex beats over seven phases of handshake timing.",
             sb.polygons_closed, sb.beats_seen);
    $display("%0d points lay on a boundary and %0d were counted inside; strict_mode ran at 1 and 0.",
             sb.boundary_hits, sb.inside_count);
    if (sb.errors == 0) begin
      $display("PASS point_in_polygon_test");
    end else begin
      $display("FAIL point_in_polygon_test");
    end
    $finish;
  end

endmodule
